// File: design/mlfq_pkg.sv
// Shared types and constants for the multilevel feedback queue scheduler.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package mlfq_pkg;

    // Task ids and slice counters have fixed widths.
    localparam int ID_W     = 4;
    localparam int NUM_IDS  = 16;
    localparam int SLICE_W  = 11;
    localparam int UNIT_W   = 8;
    localparam int SLVL_W   = 2;

    // Item kinds carried on the input tuser.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_ADMIT = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_SLICE_UNIT  = 1'b0;
    localparam logic CFG_START_LEVEL = 1'b1;

    localparam logic [UNIT_W-1:0] SLICE_UNIT_RESET  = 8'd10;
    localparam logic [SLVL_W-1:0] START_LEVEL_RESET = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic is_admit;
        logic present;
        logic found;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// File: design/mlfq_ctrl.sv
// Sequencing state machine of the scheduler.
// Depends on mlfq_pkg; drives the datapath through dp_cmd_t and reads dp_status_t.
`default_nettype none

module mlfq_ctrl
    import mlfq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // Only a tick that finds a queued task needs the load state for the registered table read.
                if (!status.is_admit && status.present && status.found)
                begin
                    state_next = ST_LOAD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            ST_LOAD:
            begin
                cmd.load = 1'b1;
            end
            ST_DONE:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/mlfq_datapath.sv
// Task tables, per-level queue pointers, running-task registers and output register.
// Depends on mlfq_pkg; commanded by mlfq_ctrl.
`default_nettype none

module mlfq_datapath
    import mlfq_pkg::*;
#(
    parameter int LEVELS    = 4,
    parameter int MAX_TASKS = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_index,
    input  wire logic [7:0]         cfg_data,
    input  wire logic               in_op,
    input  wire logic [ID_W-1:0]    in_id,
    input  wire dp_cmd_t            cmd,
    output dp_status_t              status,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [15:0]             m_tdata
);

    localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    logic [UNIT_W-1:0]  slice_unit_reg;
    logic [SLVL_W-1:0]  start_level_reg;

    logic               op_reg;
    logic [ID_W-1:0]    id_reg;

    logic               present_reg;
    logic [ID_W-1:0]    run_id_reg;
    logic [LVL_W-1:0]   run_level_reg;
    logic [SLICE_W-1:0] run_slice_reg;

    logic [NUM_IDS-1:0] known_reg;
    logic [CNT_W-1:0]   known_cnt_reg;

    logic [ID_W-1:0]    head_reg [LEVELS];
    logic [ID_W-1:0]    tail_reg [LEVELS];
    logic [CNT_W-1:0]   cnt_reg  [LEVELS];
    logic [ID_W-1:0]    head_next [LEVELS];
    logic [ID_W-1:0]    tail_next [LEVELS];
    logic [CNT_W-1:0]   cnt_next  [LEVELS];

    logic [LVL_W-1:0]   pop_lvl_reg;
    logic [ID_W-1:0]    nxt_reg;
    logic               skip_head_reg;
    logic               sw_reg;
    logic               err_reg;

    logic [SLICE_W-1:0] slice_mem [NUM_IDS];
    logic [ID_W-1:0]    link_mem  [NUM_IDS];
    logic [SLICE_W-1:0] slice_rd_reg;
    logic [ID_W-1:0]    link_rd_reg;

    logic               out_valid_reg;
    logic [15:0]        out_data_reg;

    logic [LVL_W-1:0]   lvl0;
    logic               expire;
    logic [LVL_W-1:0]   new_lvl;
    logic [LVL_W:0]     lvl_inc;
    logic [SLICE_W-1:0] reload;
    logic [SLICE_W-1:0] new_slice;
    logic               found;
    logic [LVL_W-1:0]   pop_lvl;
    logic [ID_W-1:0]    nxt;
    logic               do_tick;
    logic               switch_go;
    logic               do_admit;
    logic               full;
    logic               admit_new;
    logic               admit_queue;
    logic               push_go;
    logic [ID_W-1:0]    push_id;
    logic [LVL_W-1:0]   push_lvl;
    logic [CNT_W-1:0]   push_base;
    logic               push_empty;
    logic               slice_we;
    logic [ID_W-1:0]    slice_waddr;
    logic [SLICE_W-1:0] slice_wdata;
    logic               link_we;
    logic [ID_W-1:0]    link_waddr;
    logic [LVL_W+1:0]   lvl_ext;

    // Start level saturates at the lowest priority level.
    always_comb
    begin
        if (int'(start_level_reg) >= LEVELS)
        begin
            lvl0 = LVL_W'(LEVELS - 1);
        end
        else
        begin
            lvl0 = LVL_W'(start_level_reg);
        end
    end

    // Slice charge for the running task.
    always_comb
    begin
        expire  = (run_slice_reg <= SLICE_W'(1));
        new_lvl = run_level_reg;
        if (expire && (int'(run_level_reg) < LEVELS - 1))
        begin
            new_lvl = run_level_reg + LVL_W'(1);
        end
        lvl_inc   = {1'b0, new_lvl} + (LVL_W + 1)'(1);
        reload    = SLICE_W'(slice_unit_reg) * SLICE_W'(lvl_inc);
        new_slice = expire ? reload : (run_slice_reg - SLICE_W'(1));
    end

    // Highest non-empty level; level 0 is the highest priority.
    always_comb
    begin
        found   = 1'b0;
        pop_lvl = '0;
        for (int l = LEVELS - 1; l >= 0; l--)
        begin
            if (cnt_reg[l] != '0)
            begin
                found   = 1'b1;
                pop_lvl = LVL_W'(l);
            end
        end
    end

    assign nxt = head_reg[pop_lvl];

    always_comb
    begin
        do_tick     = cmd.exec && (op_reg == OP_TICK) && present_reg;
        switch_go   = do_tick && found;
        do_admit    = cmd.exec && (op_reg == OP_ADMIT);
        full        = (known_cnt_reg >= CNT_W'(MAX_TASKS));
        admit_new   = do_admit && !full && !known_reg[id_reg];
        admit_queue = admit_new && present_reg;

        push_go   = switch_go || admit_queue;
        push_id   = switch_go ? run_id_reg : id_reg;
        push_lvl  = switch_go ? new_lvl : lvl0;
        // The pop happens first, so a push into the same level sees the reduced count.
        push_base = cnt_reg[push_lvl];
        if (switch_go && (pop_lvl == push_lvl))
        begin
            push_base = cnt_reg[push_lvl] - CNT_W'(1);
        end
        push_empty = (push_base == '0);

        slice_we    = switch_go || admit_queue;
        slice_waddr = switch_go ? run_id_reg : id_reg;
        slice_wdata = switch_go ? new_slice : SLICE_W'(slice_unit_reg);
        link_we     = push_go && !push_empty;
        link_waddr  = tail_reg[push_lvl];
    end

    always_comb
    begin
        for (int l = 0; l < LEVELS; l++)
        begin
            head_next[l] = head_reg[l];
            tail_next[l] = tail_reg[l];
            cnt_next[l]  = cnt_reg[l];
            if (switch_go && (LVL_W'(l) == pop_lvl))
            begin
                cnt_next[l] = cnt_next[l] - CNT_W'(1);
            end
            if (push_go && (LVL_W'(l) == push_lvl))
            begin
                cnt_next[l] = cnt_next[l] + CNT_W'(1);
            end
        end
        if (push_go)
        begin
            if (push_empty)
            begin
                head_next[push_lvl] = push_id;
            end
            tail_next[push_lvl] = push_id;
        end
        if (cmd.load && !skip_head_reg)
        begin
            head_next[pop_lvl_reg] = link_rd_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_unit_reg  <= SLICE_UNIT_RESET;
            start_level_reg <= START_LEVEL_RESET;
            present_reg     <= 1'b0;
            run_id_reg      <= '0;
            run_level_reg   <= '0;
            known_reg       <= '0;
            known_cnt_reg   <= '0;
            out_valid_reg   <= 1'b0;
            for (int l = 0; l < LEVELS; l++)
            begin
                head_reg[l] <= '0;
                tail_reg[l] <= '0;
                cnt_reg[l]  <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_SLICE_UNIT:  slice_unit_reg  <= cfg_data;
                    CFG_START_LEVEL: start_level_reg <= cfg_data[SLVL_W-1:0];
                    default:         slice_unit_reg  <= slice_unit_reg;
                endcase
            end

            for (int l = 0; l < LEVELS; l++)
            begin
                head_reg[l] <= head_next[l];
                tail_reg[l] <= tail_next[l];
                cnt_reg[l]  <= cnt_next[l];
            end

            if (admit_new)
            begin
                known_reg[id_reg] <= 1'b1;
                known_cnt_reg     <= known_cnt_reg + CNT_W'(1);
            end

            if (admit_new && !present_reg)
            begin
                present_reg   <= 1'b1;
                run_id_reg    <= id_reg;
                run_level_reg <= lvl0;
            end
            else if (do_tick && !found)
            begin
                run_level_reg <= new_lvl;
            end
            else if (cmd.load)
            begin
                run_id_reg    <= nxt_reg;
                run_level_reg <= pop_lvl_reg;
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= in_op;
            id_reg <= in_id;
        end

        if (admit_new && !present_reg)
        begin
            run_slice_reg <= SLICE_W'(slice_unit_reg);
        end
        else if (do_tick && !found)
        begin
            run_slice_reg <= new_slice;
        end
        else if (cmd.load)
        begin
            run_slice_reg <= slice_rd_reg;
        end

        if (switch_go)
        begin
            pop_lvl_reg   <= pop_lvl;
            nxt_reg       <= nxt;
            skip_head_reg <= (pop_lvl == push_lvl) && push_empty;
        end

        if (cmd.exec)
        begin
            sw_reg  <= switch_go;
            err_reg <= do_admit && full;
        end

        if (cmd.out_load)
        begin
            out_data_reg <= {7'b0, err_reg, sw_reg, lvl_ext[1:0] & {2{present_reg}},
                             run_id_reg & {ID_W{present_reg}}, present_reg};
        end
    end

    // Slice and link tables of the queued tasks.
    always_ff @(posedge clk)
    begin
        if (slice_we)
        begin
            slice_mem[slice_waddr] <= slice_wdata;
        end
        if (link_we)
        begin
            link_mem[link_waddr] <= push_id;
        end
        slice_rd_reg <= slice_mem[nxt];
        link_rd_reg  <= link_mem[nxt];
    end

    assign lvl_ext = {2'b0, run_level_reg};

    always_comb
    begin
        status.is_admit = (op_reg == OP_ADMIT);
        status.present  = present_reg;
        status.found    = found;
        status.out_free = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// File: design/mlfq_task_scheduler.sv
// Multilevel feedback queue scheduler over 4-bit task ids. Each item is a tick
// (tuser 0) or an admission of the id in tdata (tuser 1), and gives exactly one
// result: the running task after the item, its level, and switch and error flags.
// A tick that switches to a queued task goes from acceptance to the output
// register through accept, update, memory read of the popped task's link and
// slice, and result; any other item skips the memory read step, needed for the
// registered link and slice table read. A new item is taken while the previous
// result waits in the output register. Queue pointers and the per-id known bits
// are flip-flops cleared by reset, so no clearing pass is needed. Configuration
// writes are accepted in every cycle and must be made only while idle.
// Depends on mlfq_pkg, mlfq_ctrl and mlfq_datapath.
`default_nettype none

module mlfq_task_scheduler
    import mlfq_pkg::*;
#(
    parameter int LEVELS    = 4,
    parameter int MAX_TASKS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [3:0] task_id, [7:4] zero
    input  wire logic        s_tuser,   // [0] op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // [0] running_valid, [4:1] running_id,
                                        // [6:5] running_level, [7] switched,
                                        // [8] error, [15:9] zero
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    mlfq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mlfq_datapath #(
        .LEVELS    (LEVELS),
        .MAX_TASKS (MAX_TASKS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_op     (s_tuser),
        .in_id     (s_tdata[ID_W-1:0]),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

// File: test/mlfq_sched_checker.sv
`timescale 1ns / 100ps
// Scoreboard for mlfq_task_scheduler. It follows every accepted tick, admission and
// register write, keeps its own copy of the run queues and checks each result.
// Depends on mlfq_pkg.

module mlfq_sched_checker
    import mlfq_pkg::*;
#(
    parameter int LEVELS    = 4,
    parameter int MAX_TASKS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [3:0] task_id, [7:4] zero
    input  wire logic        s_tuser,   // [0] op
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,   // [0] running_valid, [4:1] running_id,
                                        // [6:5] running_level, [7] switched,
                                        // [8] error, [15:9] zero
    output int               mismatch_count,
    output int               runs_awaited
);

    typedef struct packed {
        logic              running_valid;
        logic [ID_W-1:0]   running_id;
        logic [SLVL_W-1:0] running_level;
        logic              switched;
        logic              error;
    } sched_result_t;

    logic [UNIT_W-1:0]  slice_unit;
    logic [SLVL_W-1:0]  start_level;
    logic               busy;
    logic [ID_W-1:0]    run_id;
    logic [SLVL_W-1:0]  task_level [NUM_IDS];
    logic [SLICE_W-1:0] slice_left [NUM_IDS];
    logic [ID_W-1:0]    link_next  [NUM_IDS];
    logic               known      [NUM_IDS];
    logic [ID_W-1:0]    lvl_head   [LEVELS];
    logic [ID_W-1:0]    lvl_tail   [LEVELS];
    logic [4:0]         lvl_count  [LEVELS];

    sched_result_t expected_runs [$];

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("%0t: %s is %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic clear_schedule();
        slice_unit  = SLICE_UNIT_RESET;
        start_level = START_LEVEL_RESET;
        busy        = 1'b0;
        run_id      = '0;
        for (int i = 0; i < NUM_IDS; i++)
        begin
            task_level[i] = '0;
            slice_left[i] = '0;
            link_next[i]  = '0;
            known[i]      = 1'b0;
        end
        for (int l = 0; l < LEVELS; l++)
        begin
            lvl_head[l]  = '0;
            lvl_tail[l]  = '0;
            lvl_count[l] = '0;
        end
        expected_runs.delete();
    endtask

    task automatic enqueue_task(input logic [ID_W-1:0] id, input logic [SLVL_W-1:0] lvl);
        if (lvl_count[lvl] == 0)
            lvl_head[lvl] = id;
        else
            link_next[lvl_tail[lvl]] = id;
        lvl_tail[lvl]  = id;
        link_next[id]  = '0;
        lvl_count[lvl] = lvl_count[lvl] + 1'b1;
    endtask

    task automatic advance_schedule(input logic op, input logic [ID_W-1:0] id);
        sched_result_t     res;
        logic [ID_W-1:0]   popped;
        logic [SLVL_W-1:0] entry_level;
        int                in_use;
        bit                moved;
        res    = '0;
        moved  = 1'b0;
        in_use = busy ? 1 : 0;
        entry_level = (int'(start_level) >= LEVELS) ? SLVL_W'(LEVELS - 1) : start_level;
        if (op == OP_TICK)
        begin
            if (busy)
            begin
                // Charge one unit; an exhausted slice demotes and reloads.
                if (slice_left[run_id] <= 1)
                begin
                    if (int'(task_level[run_id]) < LEVELS - 1)
                        task_level[run_id] = task_level[run_id] + 1'b1;
                    slice_left[run_id] =
                        SLICE_W'(int'(slice_unit) * (int'(task_level[run_id]) + 1));
                end
                else
                    slice_left[run_id] = slice_left[run_id] - 1'b1;
                for (int l = 0; l < LEVELS; l++)
                begin
                    if (!moved && lvl_count[l] != 0)
                    begin
                        popped = lvl_head[l];
                        lvl_head[l]  = link_next[popped];
                        lvl_count[l] = lvl_count[l] - 1'b1;
                        link_next[popped] = '0;
                        enqueue_task(run_id, task_level[run_id]);
                        run_id = popped;
                        moved  = 1'b1;
                    end
                end
            end
            res.switched = moved;
        end
        else
        begin
            for (int l = 0; l < LEVELS; l++)
                in_use += lvl_count[l];
            if (in_use >= MAX_TASKS)
                res.error = 1'b1;
            else if (!known[id])
            begin
                known[id]      = 1'b1;
                task_level[id] = entry_level;
                slice_left[id] = SLICE_W'(slice_unit);
                link_next[id]  = '0;
                if (!busy)
                begin
                    run_id = id;
                    busy   = 1'b1;
                end
                else
                    enqueue_task(id, entry_level);
            end
        end
        res.running_valid = busy;
        if (busy)
        begin
            res.running_id    = run_id;
            res.running_level = task_level[run_id];
        end
        expected_runs.push_back(res);
    endtask

    task automatic check_result(input logic [15:0] data);
        sched_result_t want;
        sched_result_t got;
        got.running_valid = data[0];
        got.running_id    = data[4:1];
        got.running_level = data[6:5];
        got.switched      = data[7];
        got.error         = data[8];
        if (expected_runs.size() == 0)
        begin
            flag_mismatch("unexpected result item, tdata", int'(data), 0);
            return;
        end
        want = expected_runs.pop_front();
        if (got.running_valid !== want.running_valid)
            flag_mismatch("running_valid", got.running_valid, want.running_valid);
        if (got.running_id !== want.running_id)
            flag_mismatch("running_id", got.running_id, want.running_id);
        if (got.running_level !== want.running_level)
            flag_mismatch("running_level", got.running_level, want.running_level);
        if (got.switched !== want.switched)
            flag_mismatch("switched", got.switched, want.switched);
        if (got.error !== want.error)
            flag_mismatch("error", got.error, want.error);
    endtask

    // All handshakes are sampled at the edge that completes them.
    always @(posedge clk)
    begin
        if (!rst_n)
            clear_schedule();
        else
        begin
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_SLICE_UNIT)
                    slice_unit = cfg_data;
                else
                    start_level = cfg_data[SLVL_W-1:0];
            end
            if (s_tvalid && s_tready)
                advance_schedule(s_tuser, s_tdata[ID_W-1:0]);
        end
        runs_awaited = expected_runs.size();
    end

endmodule

// File: test/mlfq_task_scheduler_test.sv
`timescale 1ns / 100ps
// Test top for mlfq_task_scheduler: clock, reset, item and register stimulus,
// output back-pressure and the verdict. Depends on mlfq_pkg and mlfq_sched_checker.

module mlfq_task_scheduler_test
    import mlfq_pkg::*;
();

    localparam int LEVELS        = 4;
    localparam int MAX_TASKS     = 16;
    localparam int RANDOM_ROUNDS = 6;
    localparam int ROUND_ITEMS   = 120;
    localparam int HOLD_CYCLES   = 150;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_SLICE_UNIT;
    logic [7:0]  cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tuser   = OP_TICK;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;

    int mismatch_count;
    int runs_awaited;
    int tx_idle_pct   = 20;
    int rx_idle_pct   = 68;
    int holds_asked   = 0;
    int holds_granted = 0;
    int hold_left     = 0;

    mlfq_task_scheduler #(.LEVELS(LEVELS), .MAX_TASKS(MAX_TASKS)) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    mlfq_sched_checker #(.LEVELS(LEVELS), .MAX_TASKS(MAX_TASKS)) sched_check (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .mismatch_count(mismatch_count), .runs_awaited(runs_awaited)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Output side: random stalls, plus a long hold-off whenever one is asked for.
    always @(posedge clk)
    begin
        if (holds_granted != holds_asked)
        begin
            holds_granted++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic write_register(input logic idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_schedule(input logic [7:0] unit, input logic [SLVL_W-1:0] lvl);
        write_register(CFG_SLICE_UNIT, unit);
        write_register(CFG_START_LEVEL, {6'b0, lvl});
    endtask

    // Returns at the edge that accepted the item, with tvalid still high, so a
    // following item can be offered back to back.
    task automatic send_item(input logic op, input logic [ID_W-1:0] id);
        int gap;
        gap = 0;
        while (gap < 12 && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, id};
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (runs_awaited != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: a single task alone, a switch, and then the table filled
        // under three register settings until an admission is refused.
        set_schedule(8'd1, 2'd0);
        send_item(OP_TICK, 4'd0);       // nothing running yet
        send_item(OP_ADMIT, 4'd0);
        send_item(OP_TICK, 4'd0);       // alone: keeps running, gets demoted
        send_item(OP_TICK, 4'd0);
        send_item(OP_ADMIT, 4'd0);      // already running, so ignored
        send_item(OP_ADMIT, 4'd15);
        send_item(OP_TICK, 4'd0);
        for (int i = 1; i <= 4; i++)
            send_item(OP_ADMIT, ID_W'(i));
        drain_results();

        set_schedule(8'd0, 2'd3);       // zero slices reload to zero
        for (int i = 5; i <= 9; i++)
            send_item(OP_ADMIT, ID_W'(i));
        send_item(OP_TICK, 4'd0);
        send_item(OP_TICK, 4'd0);
        drain_results();

        set_schedule(8'd255, 2'd2);
        for (int i = 10; i <= 14; i++)
            send_item(OP_ADMIT, ID_W'(i));
        send_item(OP_ADMIT, 4'd3);      // table is full now
        send_item(OP_TICK, 4'd0);

        for (int r = 0; r < RANDOM_ROUNDS; r++)
        begin
            drain_results();
            case (r)
                0: set_schedule(8'd3, 2'd1);
                1: set_schedule(8'd255, 2'd2);
                2: set_schedule(8'd1, 2'd3);
                3: set_schedule(8'd2, 2'd0);
                4: set_schedule(8'($urandom_range(1, 12)), 2'd1);
                default: set_schedule(8'd1, 2'd2);
            endcase
            tx_idle_pct = (r < 2) ? 20 : (r < 4) ? 68 : 0;
            rx_idle_pct = (r < 2) ? 68 : (r < 4) ? 20 : 0;
            for (int n = 0; n < ROUND_ITEMS; n++)
            begin
                if (r == 0 && n == 60)
                    holds_asked++;
                if (r == 2 && n == 60)
                    drain_results();
                send_item(($urandom_range(99) < 85) ? OP_TICK : OP_ADMIT,
                          ID_W'($urandom_range(15)));
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        @(negedge clk);
        if (mismatch_count == 0 && runs_awaited == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: filelist.f
design/mlfq_pkg.sv
design/mlfq_ctrl.sv
design/mlfq_datapath.sv
design/mlfq_task_scheduler.sv
test/mlfq_sched_checker.sv
test/mlfq_task_scheduler_test.sv
